[hw/rtl/dmic_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmic_pkg
// Shared sizes, limits and the token type for the inversion cost cell chain.
// ----------------------------------------------------------------------------
package dmic_pkg;

	localparam int MAX_LEN   = 1024;
	localparam int CNT_W     = $clog2(MAX_LEN + 1);
	localparam int VAL_W     = 32;
	localparam int COST_W    = 10;
	localparam int TOTAL_W   = 19;
	localparam int TACC_W    = 20;
	localparam int COST_MAX  = 512;
	localparam int TOTAL_MAX = 523776;

	typedef struct packed {
		logic                    first;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        idx;
		logic [CNT_W-1:0]        gt;
		logic [CNT_W-1:0]        lt;
	} dmic_tok_t;

endpackage

[hw/rtl/dmic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmic_cell
// One cell of the chain: holds one stored value, compares it with the passing
// token, bumps the token's greater or less count and hands it to the next cell.
// ----------------------------------------------------------------------------
module dmic_cell import dmic_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [CNT_W-1:0] pos,
	input  logic             tok_vld_i,
	input  dmic_tok_t        tok_i,
	output logic             tok_vld_o,
	output dmic_tok_t        tok_o
);

	logic signed [VAL_W-1:0] stored_q;
	logic                    vld_q;
	dmic_tok_t               tok_q;
	dmic_tok_t               tok_d;

	always_comb begin
		tok_d = tok_i;
		if (tok_i.idx > pos) begin
			if ($signed(stored_q) > $signed(tok_i.value)) begin
				tok_d.gt = tok_i.gt + CNT_W'(1);
			end else if ($signed(stored_q) < $signed(tok_i.value)) begin
				tok_d.lt = tok_i.lt + CNT_W'(1);
			end
		end
	end

	// store the value whose sequence index lands on this cell
	always_ff @(posedge clk) begin
		if (adv && tok_vld_i && (tok_i.idx == pos)) begin
			stored_q <= tok_i.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_d;
		end
	end

	assign tok_vld_o = vld_q;
	assign tok_o     = tok_q;

endmodule

[hw/rtl/dmic_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmic_out
// Tail of the chain: takes min of the counts, keeps the running total and
// holds the result beat; drives the chain-wide advance.
// ----------------------------------------------------------------------------
module dmic_out import dmic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               out_ready,
	input  logic               tok_vld,
	input  dmic_tok_t          tok,
	output logic               adv,
	output logic               out_valid,
	output logic [COST_W-1:0]  item_cost,
	output logic [TOTAL_W-1:0] total_cost,
	output logic               overflow
);

	logic                valid_q;
	logic [TACC_W-1:0]   total_q;
	logic [COST_W-1:0]   cost_q;
	logic [TOTAL_W-1:0]  tot_out_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    cost_min;
	logic [COST_W-1:0]   cost_sat;
	logic [TACC_W-1:0]   base;
	logic [TACC_W-1:0]   sum;
	logic [TACC_W-1:0]   total_n;

	assign adv = !valid_q || out_ready;

	always_comb begin
		cost_min = (tok.gt < tok.lt) ? tok.gt : tok.lt;
		if (32'(cost_min) > 32'(COST_MAX)) begin
			cost_sat = COST_W'(COST_MAX);
		end else begin
			cost_sat = COST_W'(cost_min);
		end
		base    = tok.first ? '0 : total_q;
		sum     = base + TACC_W'(cost_sat);
		total_n = (sum > TACC_W'(TOTAL_MAX)) ? TACC_W'(TOTAL_MAX) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			total_q <= '0;
		end else if (adv) begin
			valid_q <= tok_vld;
			if (tok_vld) begin
				total_q <= total_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cost_q    <= cost_sat;
			tot_out_q <= TOTAL_W'(total_n);
			ovf_q     <= (tok.idx == CNT_W'(MAX_LEN));
		end
	end

	assign out_valid  = valid_q;
	assign item_cost  = cost_q;
	assign total_cost = tot_out_q;
	assign overflow   = ovf_q;

endmodule

[hw/rtl/deque_min_inversion_cost_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_min_inversion_cost_unit
// Per-item greedy inversion cost (min of earlier greater / earlier less) and
// running total over a sequence, computed by a chain of MAX_LEN compare cells.
// ----------------------------------------------------------------------------
// Throughput is one beat per cycle while no result beat waits on out_ready;
// each beat walks through the cell chain and then the result register before
// its result appears. The whole chain
// advances together and holds while a result beat waits on out_ready. A beat
// with first set opens a new sequence; beats past MAX_LEN in one sequence
// report overflow and are not stored. No clearing pass is needed after reset.
module deque_min_inversion_cost_unit import dmic_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    first,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COST_W-1:0]       item_cost,
	output logic [TOTAL_W-1:0]      total_cost,
	output logic                    overflow
);

	logic             adv;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_in;
	logic             in_acc;
	logic             vld_c [MAX_LEN+1];
	dmic_tok_t        tok_c [MAX_LEN+1];

	assign in_ready = adv;
	assign in_acc   = in_valid && adv;
	assign idx_in   = first ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			if (idx_in == CNT_W'(MAX_LEN)) begin
				count_q <= idx_in;
			end else begin
				count_q <= idx_in + CNT_W'(1);
			end
		end
	end

	assign vld_c[0]       = in_valid;
	assign tok_c[0].first = first;
	assign tok_c[0].value = value;
	assign tok_c[0].idx   = idx_in;
	assign tok_c[0].gt    = '0;
	assign tok_c[0].lt    = '0;

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		dmic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.pos       (CNT_W'(i)),
			.tok_vld_i (vld_c[i]),
			.tok_i     (tok_c[i]),
			.tok_vld_o (vld_c[i+1]),
			.tok_o     (tok_c[i+1])
		);
	end

	dmic_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.out_ready  (out_ready),
		.tok_vld    (vld_c[MAX_LEN]),
		.tok        (tok_c[MAX_LEN]),
		.adv        (adv),
		.out_valid  (out_valid),
		.item_cost  (item_cost),
		.total_cost (total_cost),
		.overflow   (overflow)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("sequence count beyond store depth");

	a_first_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && first |=> count_q == CNT_W'(1))
		else $error("first beat did not restart the sequence");

	a_count_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !first && count_q == CNT_W'(MAX_LEN) |=> count_q == CNT_W'(MAX_LEN))
		else $error("full store count moved");

	a_total_covers_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> TOTAL_W'(item_cost) <= total_cost)
		else $error("running total below item cost");

	a_cost_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_cost <= COST_W'(COST_MAX))
		else $error("item cost above limit");

endmodule
